// ===== rtl/cbrb_pkg.sv =====
// Package for the capture burst record builder.
// Holds the shared constants, request and register codes, record offsets and structs.
// No dependencies; every other file in rtl/ uses it.
package cbrb_pkg;

  // Payload capacity of one burst and the widths that follow from it.
  localparam int BURST_BYTES = 32;
  localparam int CNT_W       = 6;
  localparam int PL_AW       = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;
  localparam int HDR_BYTES   = 12;
  localparam int IDX_W       = $clog2(HDR_BYTES + BURST_BYTES);

  // Record constants.
  localparam logic [7:0]  REC_TYPE_DATA = 8'h01;
  localparam logic [15:0] SAT16         = 16'hFFFF;

  // Request codes.
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_OVERRUN = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDLE_GAP = 2'd0;
  localparam logic [1:0] CFG_TIME_CAP = 2'd1;
  localparam logic [1:0] CFG_ONSET    = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]       RST_IDLE_GAP = 8'd3;
  localparam logic [31:0]      RST_TIME_CAP = 32'd50000;
  localparam logic [CNT_W-1:0] RST_ONSET    = 6'd16;

  // Byte offsets of the record header fields.
  localparam int OFS_TYPE  = 0;
  localparam int OFS_START = 1;
  localparam int OFS_DUR   = 5;
  localparam int OFS_ONSET = 7;
  localparam int OFS_FLAGS = 9;
  localparam int OFS_LEN   = 10;

  // Result of the shared subtractor.
  typedef struct packed {
    logic        borrow;
    logic [31:0] diff;
  } alu_res_t;

  // Header fields of the record being emitted.
  typedef struct packed {
    logic [31:0]      start;
    logic [15:0]      dur;
    logic [15:0]      onset;
    logic             overrun;
    logic             cont;
    logic [CNT_W-1:0] len;
  } rec_hdr_t;

  // Saturate a 32-bit time difference to 16 bits.
  function automatic logic [15:0] sat16(input logic [31:0] v);
    sat16 = (v[31:16] != 16'd0) ? SAT16 : v[15:0];
  endfunction

endpackage

// ===== rtl/cbrb_alu.sv =====
// Shared 32-bit subtractor of the burst record builder.
// Gives a - b modulo 2^32 and the borrow, which flags b > a. Uses cbrb_pkg.
module cbrb_alu (
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  output cbrb_pkg::alu_res_t res_o
);

  logic [32:0] sub;

  // One wide subtract serves every time difference and every compare.
  assign sub = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.borrow = sub[32];
  assign res_o.diff   = sub[31:0];

endmodule

// ===== rtl/cbrb_rec_fmt.sv =====
// Record byte selector of the burst record builder.
// Picks the record byte at a given position from the header fields or the payload.
// Uses cbrb_pkg.
module cbrb_rec_fmt (
  input  logic [cbrb_pkg::IDX_W-1:0] idx_i,
  input  cbrb_pkg::rec_hdr_t         hdr_i,
  input  logic [7:0]                 payload_i,
  output logic [7:0]                 byte_o,
  output logic                       end_o
);

  logic [15:0] len16;
  logic [7:0]  flags;

  assign len16 = 16'(hdr_i.len);
  assign flags = {5'd0, hdr_i.cont, 1'b0, hdr_i.overrun};

  // Little-endian header fields, then the payload.
  always_comb begin
    case (idx_i)
      cbrb_pkg::IDX_W'(cbrb_pkg::OFS_TYPE):      byte_o = cbrb_pkg::REC_TYPE_DATA;
      cbrb_pkg::IDX_W'(cbrb_pkg::OFS_START):     byte_o = hdr_i.start[7:0];
      cbrb_pkg::IDX_W'(cbrb_pkg::OFS_START + 1): byte_o = hdr_i.start[15:8];
      cbrb_pkg::IDX_W'(cbrb_pkg::OFS_START + 2): byte_o = hdr_i.start[23:16];
      cbrb_pkg::IDX_W'(cbrb_pkg::OFS_START + 3): byte_o = hdr_i.start[31:24];
      cbrb_pkg::IDX_W'(cbrb_pkg::OFS_DUR):       byte_o = hdr_i.dur[7:0];
      cbrb_pkg::IDX_W'(cbrb_pkg::OFS_DUR + 1):   byte_o = hdr_i.dur[15:8];
      cbrb_pkg::IDX_W'(cbrb_pkg::OFS_ONSET):     byte_o = hdr_i.onset[7:0];
      cbrb_pkg::IDX_W'(cbrb_pkg::OFS_ONSET + 1): byte_o = hdr_i.onset[15:8];
      cbrb_pkg::IDX_W'(cbrb_pkg::OFS_FLAGS):     byte_o = flags;
      cbrb_pkg::IDX_W'(cbrb_pkg::OFS_LEN):       byte_o = len16[7:0];
      cbrb_pkg::IDX_W'(cbrb_pkg::OFS_LEN + 1):   byte_o = len16[15:8];
      default:                                   byte_o = payload_i;
    endcase
  end

  // The record ends after the header and len payload bytes.
  assign end_o = (idx_i == (cbrb_pkg::IDX_W'(cbrb_pkg::HDR_BYTES - 1)
                            + cbrb_pkg::IDX_W'(hdr_i.len)));

endmodule

// ===== rtl/capture_burst_record_builder_unit.sv =====
// Top level of the capture burst record builder: sequencer, payload memory, output register.
// Depends on cbrb_pkg, cbrb_alu and cbrb_rec_fmt.
//
// Usage: words enter on the input channel (in_valid_i / in_stall_o) as a request type
// with a data byte and the microsecond and millisecond timestamps. Record bytes leave on
// the output channel (out_valid_o / out_stall_i), one byte per word, record_end_o set on
// the last byte of a record. Configuration is written through cfg_we_i, cfg_index_i and
// cfg_wdata_i, by the user only while the block is idle; the block does not enforce this.
// Operation: a small sequencer runs every time difference and compare through one shared
// 32-bit subtractor. An overrun word, an unused request type or a tick without an open
// burst ends in S_IDLE; a captured byte passes S_BYTE and S_ONSET, a tick with a burst
// open S_MS, S_GAP, S_US and S_CAP. A byte that fills the payload, or a tick that
// closes the burst, passes S_DUR for the duration and streams 12 + n bytes, one per cycle
// while the receiver does not stall; n is the payload length, at most 32. in_stall_o
// stays high while the sequencer works, so one word is processed at a time. The output
// register lets the next word be taken while the last record byte still waits.
// Reset clears all state but the payload memory and loads the register defaults: idle gap
// 3 ms, time cap 50000 us, onset count 16. A stalling receiver holds the current byte and
// halts the record stream; the payload memory needs no clearing pass.
module capture_burst_record_builder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] now_us_i,
  input  logic [31:0] now_ms_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  record_byte_o,
  output logic        record_end_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BYTE,
    S_ONSET,
    S_MS,
    S_GAP,
    S_US,
    S_CAP,
    S_DUR,
    S_EMIT
  } state_e;

  localparam int CW = cbrb_pkg::CNT_W;
  localparam int IW = cbrb_pkg::IDX_W;
  localparam int AW = cbrb_pkg::PL_AW;

  state_e state_q, state_d;

  // Configuration registers.
  logic [7:0]    idle_gap_q, idle_gap_d;
  logic [31:0]   time_cap_q, time_cap_d;
  logic [CW-1:0] onset_cnt_q, onset_cnt_d;

  // Captured input word.
  logic [1:0]  req_q, req_d;
  logic [7:0]  data_q, data_d;
  logic [31:0] now_us_q, now_us_d;
  logic [31:0] now_ms_q, now_ms_d;

  // Burst state.
  logic          open_q, open_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   start_q, start_d;
  logic [31:0]   last_us_q, last_us_d;
  logic [31:0]   last_ms_q, last_ms_d;
  logic [15:0]   onset_q, onset_d;
  logic          ovr_q, ovr_d;

  // Sequencer scratch.
  logic [31:0] diff_q, diff_d;
  logic        close_q, close_d;
  logic        cont_q, cont_d;
  logic [15:0] dur_q, dur_d;
  logic [IW-1:0] idx_q, idx_d;

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_end_q, out_end_d;

  // Payload memory.
  logic [7:0]    payload_mem [cbrb_pkg::BURST_BYTES];
  logic [7:0]    rd_data_q;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [IW-1:0] rd_pos;

  // Shared unit and record formatter hookup.
  logic [31:0]        alu_a, alu_b;
  cbrb_pkg::alu_res_t alu_res;
  cbrb_pkg::rec_hdr_t hdr;
  logic [7:0]         fmt_byte;
  logic               fmt_end;

  logic in_accept;
  logic out_free;
  logic [CW-1:0] cnt_base;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cnt_base   = open_q ? cnt_q : '0;

  // Operand selection for the shared subtractor.
  always_comb begin
    case (state_q)
      S_ONSET: begin alu_a = now_us_q;            alu_b = start_q; end
      S_MS:    begin alu_a = now_ms_q;            alu_b = last_ms_q; end
      S_GAP:   begin alu_a = {24'd0, idle_gap_q}; alu_b = diff_q; end
      S_US:    begin alu_a = now_us_q;            alu_b = start_q; end
      S_CAP:   begin alu_a = time_cap_q;          alu_b = diff_q; end
      S_DUR:   begin alu_a = last_us_q;           alu_b = start_q; end
      default: begin alu_a = now_us_q;            alu_b = start_q; end
    endcase
  end

  cbrb_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // Header fields of the record in flight.
  assign hdr.start   = start_q;
  assign hdr.dur     = dur_q;
  assign hdr.onset   = onset_q;
  assign hdr.overrun = ovr_q;
  assign hdr.cont    = cont_q;
  assign hdr.len     = cnt_q;

  cbrb_rec_fmt u_rec_fmt (
    .idx_i     (idx_q),
    .hdr_i     (hdr),
    .payload_i (rd_data_q),
    .byte_o    (fmt_byte),
    .end_o     (fmt_end)
  );

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    idle_gap_d  = idle_gap_q;
    time_cap_d  = time_cap_q;
    onset_cnt_d = onset_cnt_q;
    req_d       = req_q;
    data_d      = data_q;
    now_us_d    = now_us_q;
    now_ms_d    = now_ms_q;
    open_d      = open_q;
    cnt_d       = cnt_q;
    start_d     = start_q;
    last_us_d   = last_us_q;
    last_ms_d   = last_ms_q;
    onset_d     = onset_q;
    ovr_d       = ovr_q;
    diff_d      = diff_q;
    close_d     = close_q;
    cont_d      = cont_q;
    dur_d       = dur_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    mem_we      = 1'b0;
    wr_addr     = cnt_base[AW-1:0];

    // Configuration writes.
    if (cfg_we_i) begin
      case (cfg_index_i)
        cbrb_pkg::CFG_IDLE_GAP: idle_gap_d  = cfg_wdata_i[7:0];
        cbrb_pkg::CFG_TIME_CAP: time_cap_d  = cfg_wdata_i;
        cbrb_pkg::CFG_ONSET:    onset_cnt_d = cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      // Take a word and dispatch on its type.
      S_IDLE: begin
        if (in_accept) begin
          req_d    = req_type_i;
          data_d   = data_byte_i;
          now_us_d = now_us_i;
          now_ms_d = now_ms_i;
          case (req_type_i)
            cbrb_pkg::REQ_BYTE:    state_d = S_BYTE;
            cbrb_pkg::REQ_TICK:    state_d = open_q ? S_MS : S_IDLE;
            cbrb_pkg::REQ_OVERRUN: ovr_d = 1'b1;
            default: ;
          endcase
        end
      end
      // Open a burst if needed, store the byte and note its times.
      S_BYTE: begin
        if (!open_q) begin
          open_d  = 1'b1;
          onset_d = 16'd0;
          start_d = now_us_q;
        end
        mem_we    = 1'b1;
        cnt_d     = cnt_base + CW'(1);
        last_us_d = now_us_q;
        last_ms_d = now_ms_q;
        state_d   = S_ONSET;
      end
      // Record the onset time, and emit a continued record when full.
      S_ONSET: begin
        if (cnt_q == onset_cnt_q) begin
          onset_d = cbrb_pkg::sat16(alu_res.diff);
        end
        if (cnt_q == CW'(cbrb_pkg::BURST_BYTES)) begin
          cont_d  = 1'b1;
          state_d = S_DUR;
        end else begin
          state_d = S_IDLE;
        end
      end
      // Milliseconds since the last byte.
      S_MS: begin
        diff_d  = alu_res.diff;
        state_d = S_GAP;
      end
      // Idle gap exceeded when the gap minus the elapsed time borrows.
      S_GAP: begin
        close_d = alu_res.borrow;
        state_d = S_US;
      end
      // Microseconds since the burst start.
      S_US: begin
        diff_d  = alu_res.diff;
        state_d = S_CAP;
      end
      // Close on either limit with a terminal record.
      S_CAP: begin
        if (close_q || alu_res.borrow) begin
          cont_d  = 1'b0;
          state_d = S_DUR;
        end else begin
          state_d = S_IDLE;
        end
      end
      // Burst duration, then start streaming.
      S_DUR: begin
        dur_d   = cbrb_pkg::sat16(alu_res.diff);
        idx_d   = '0;
        state_d = S_EMIT;
      end
      // Stream the record one byte per free output slot.
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = fmt_byte;
          out_end_d   = fmt_end;
          if (fmt_end) begin
            open_d  = 1'b0;
            cnt_d   = '0;
            ovr_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The memory reads ahead at the position the index takes next cycle.
  assign rd_pos  = idx_d - IW'(cbrb_pkg::HDR_BYTES);
  assign rd_addr = rd_pos[AW-1:0];

  // Payload memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      payload_mem[wr_addr] <= data_q;
    end
    rd_data_q <= payload_mem[rd_addr];
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idle_gap_q  <= cbrb_pkg::RST_IDLE_GAP;
      time_cap_q  <= cbrb_pkg::RST_TIME_CAP;
      onset_cnt_q <= cbrb_pkg::RST_ONSET;
      req_q       <= '0;
      data_q      <= '0;
      now_us_q    <= '0;
      now_ms_q    <= '0;
      open_q      <= 1'b0;
      cnt_q       <= '0;
      start_q     <= '0;
      last_us_q   <= '0;
      last_ms_q   <= '0;
      onset_q     <= '0;
      ovr_q       <= 1'b0;
      diff_q      <= '0;
      close_q     <= 1'b0;
      cont_q      <= 1'b0;
      dur_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_end_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      idle_gap_q  <= idle_gap_d;
      time_cap_q  <= time_cap_d;
      onset_cnt_q <= onset_cnt_d;
      req_q       <= req_d;
      data_q      <= data_d;
      now_us_q    <= now_us_d;
      now_ms_q    <= now_ms_d;
      open_q      <= open_d;
      cnt_q       <= cnt_d;
      start_q     <= start_d;
      last_us_q   <= last_us_d;
      last_ms_q   <= last_ms_d;
      onset_q     <= onset_d;
      ovr_q       <= ovr_d;
      diff_q      <= diff_d;
      close_q     <= close_d;
      cont_q      <= cont_d;
      dur_q       <= dur_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_end_q   <= out_end_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign record_byte_o = out_byte_q;
  assign record_end_o  = out_end_q;

`ifndef ASSERT_OFF
  // Between words the payload is never full: a full payload is always flushed.
  a_cnt_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> cnt_q < CW'(cbrb_pkg::BURST_BYTES))
    else $error("payload count at or above capacity while idle");

  // A closed burst holds no bytes.
  a_closed_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> cnt_q == '0)
    else $error("byte count nonzero with no open burst");

  // Records are only streamed for an open burst.
  a_emit_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> open_q)
    else $error("record streaming without an open burst");

  // Loading the last record byte closes the burst and frees the input.
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free && fmt_end) |=>
      (state_q == S_IDLE && !open_q && !ovr_q && out_valid_q && out_end_q))
    else $error("last record byte did not close the burst");
`endif

endmodule
